// ===== src/amb_pkg.sv =====
// Shared types and constants for the audio meter ballistics block.
package amb_pkg;

    localparam logic signed [15:0] SILENT    = 16'sh8000;
    localparam logic signed [15:0] LEVEL_MIN = -16'sd32767;

    // Divider operand widths.
    localparam int NUM_W = 42;
    localparam int DEN_W = 31;

    // The peak fall divides by 1000000 as a shift by 6 and a reciprocal of 15625.
    // With a 30-bit dividend, ceil(2^44 / 15625) gives the exact floor.
    localparam logic [30:0]      DECAY_RECIP = 31'd1125899907;
    localparam int               DECAY_SHIFT = 44;
    localparam logic [16:0]      MAG_SCALE  = 17'd100000;
    localparam logic [6:0]       MAG_GAIN   = 7'd99;
    localparam logic [9:0]       US_PER_MS  = 10'd1000;
    localparam logic [48:0]      IDLE_US    = 49'd500000;

    localparam logic [2:0] REG_FALL_RATE   = 3'd0;
    localparam logic [2:0] REG_MIN_LEVEL   = 3'd1;
    localparam logic [2:0] REG_INTEG_MS    = 3'd2;
    localparam logic [2:0] REG_HOLD_MS     = 3'd3;
    localparam logic [2:0] REG_IN_HOLD_MS  = 3'd4;

    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_RESET = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef struct packed {
        logic [15:0]        fall_rate;
        logic signed [15:0] minimum_level;
        logic [13:0]        integration_time_ms;
        logic [15:0]        hold_time_ms;
        logic [15:0]        input_hold_time_ms;
    } t_cfg;

    typedef struct packed {
        t_func              kind;
        logic [2:0]         ch;
        logic signed [15:0] mag;
        logic signed [15:0] peak;
        logic signed [15:0] ipeak;
        logic [47:0]        now;
        logic [19:0]        elapsed;
    } t_cmd;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DMUL,
        B_DREC,
        B_CHAN,
        B_MMUL,
        B_MSCALE,
        B_MSTART,
        B_MWAIT,
        B_OUT
    } t_bstate;

endpackage

// ===== src/amb_if.sv =====
// Channel interfaces: configuration writes, input items and result items.
interface amb_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface amb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [2:0]         channel;
    logic signed [15:0] magnitude_in;
    logic signed [15:0] peak_in;
    logic signed [15:0] input_peak_in;
    logic [47:0]        now_time;
    logic [19:0]        elapsed_time;
    modport source (output valid, func, channel, magnitude_in, peak_in, input_peak_in,
                    now_time, elapsed_time, input ready);
    modport sink   (input valid, func, channel, magnitude_in, peak_in, input_peak_in,
                    now_time, elapsed_time, output ready);
endinterface

interface amb_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_channel;
    logic signed [15:0] shown_magnitude;
    logic signed [15:0] shown_peak;
    logic signed [15:0] shown_input_peak;
    logic signed [15:0] shown_peak_hold;
    logic               idle;
    logic               last;
    modport source (output valid, out_channel, shown_magnitude, shown_peak,
                    shown_input_peak, shown_peak_hold, idle, last, input ready);
    modport sink   (input valid, out_channel, shown_magnitude, shown_peak,
                    shown_input_peak, shown_peak_hold, idle, last, output ready);
endinterface

// ===== src/amb_div.sv =====
// Restoring divider, one quotient bit per cycle.
module amb_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [amb_pkg::NUM_W-1:0]  i_num,
    input  logic [amb_pkg::DEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [amb_pkg::NUM_W-1:0]  o_quot
);
    import amb_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_r;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   rem_sh;
    logic             take;

    assign rem_sh = {r_r, r_q[NUM_W-1]};
    assign take   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_r    <= '0;
                r_den  <= i_den;
                r_cnt  <= CNT_W'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_r   <= take ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
                r_q   <= {r_q[NUM_W-2:0], take};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== src/amb_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
module amb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    amb_in_if.sink        i_in,
    output amb_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);
    import amb_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push;

    function automatic logic signed [15:0] sat_level(input logic signed [15:0] x);
        return (x > 16'sd0) ? 16'sd0 : x;
    endfunction

    assign i_in.ready = (r_cnt != 2'd2);
    // Unused function codes are taken and dropped here.
    assign push = i_in.valid && i_in.ready && (t_func'(i_in.func) != FUNC_NONE);

    always_comb begin
        n_cmd.kind    = t_func'(i_in.func);
        n_cmd.ch      = i_in.channel;
        n_cmd.mag     = sat_level(i_in.magnitude_in);
        n_cmd.peak    = sat_level(i_in.peak_in);
        n_cmd.ipeak   = sat_level(i_in.input_peak_in);
        n_cmd.now     = i_in.now_time;
        n_cmd.elapsed = i_in.elapsed_time;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = (r_cnt != 2'd0);

endmodule

// ===== src/amb_back.sv =====
// Back end: channel state, tick sequencer and result register.
module amb_back #(
    parameter int CHANNELS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  amb_pkg::t_cfg i_cfg,
    input  amb_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    amb_out_if.source     o_out
);
    import amb_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [15:0] r_smag  [CHANNELS];
    logic signed [15:0] r_speak [CHANNELS];
    logic signed [15:0] r_sipk  [CHANNELS];
    logic signed [15:0] r_dmag  [CHANNELS];
    logic signed [15:0] r_dpeak [CHANNELS];
    logic signed [15:0] r_dhold [CHANNELS];
    logic signed [15:0] r_dipk  [CHANNELS];
    logic [47:0]        r_hstamp[CHANNELS];
    logic [47:0]        r_istamp[CHANNELS];
    logic [47:0]        r_last_set;

    t_bstate            r_state, n_state;
    logic [CH_W-1:0]    r_ch;
    logic [47:0]        r_now;
    logic [19:0]        r_elapsed;
    logic               r_idle;
    logic [DEN_W-1:0]   r_tden;
    logic [16:0]        r_decay;
    logic [NUM_W-1:0]   r_prod;
    logic [35:0]        r_mp;
    logic [15:0]        r_mag;
    logic               r_neg;

    logic               r_ovalid;
    logic [2:0]         r_ochan;
    logic signed [15:0] r_omag, r_opeak, r_oipk, r_ohold;
    logic               r_oidle, r_olast;

    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_quot;

    logic signed [15:0] sp, sip, sm, dp, dh, dip, dm;
    logic signed [15:0] lvl_floor, peak_lo, peak_new;
    logic signed [18:0] peak_dec;
    logic signed [48:0] hdiff, idiff, sdiff;
    logic [25:0]        hold_us, ihold_us;
    logic               hold_load, ihold_load, ch_last, out_free, ch_ok;
    logic [35:0]        dprod, mprod;
    logic [60:0]        dscale;
    logic [NUM_W-1:0]   sprod;
    logic [13:0]        tms;
    logic signed [16:0] mdiff;
    logic [15:0]        qsat;
    logic signed [18:0] qv, madd;
    logic signed [15:0] mag_new;
    logic [CH_W-1:0]    set_idx;

    function automatic logic signed [15:0] shown(input logic signed [15:0] v);
        return (v == SILENT) ? 16'sd0 : v;
    endfunction

    amb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod),
        .i_den   (r_tden),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign sp  = r_speak[r_ch];
    assign sip = r_sipk[r_ch];
    assign sm  = r_smag[r_ch];
    assign dp  = r_dpeak[r_ch];
    assign dh  = r_dhold[r_ch];
    assign dip = r_dipk[r_ch];
    assign dm  = r_dmag[r_ch];

    assign ch_last  = (r_ch == CH_W'(CHANNELS - 1));
    assign out_free = !r_ovalid || o_out.ready;
    assign ch_ok    = (32'(i_cmd.ch) < CHANNELS);
    assign set_idx  = CH_W'(i_cmd.ch);

    always_comb begin
        lvl_floor = i_cfg.minimum_level;
        if (lvl_floor > 16'sd0) begin
            lvl_floor = 16'sd0;
        end else if (lvl_floor == SILENT) begin
            lvl_floor = LEVEL_MIN;
        end
    end

    // Peak decays linearly, never below the stored peak.
    always_comb begin
        peak_lo  = (sp == SILENT) ? LEVEL_MIN : sp;
        peak_dec = 19'(dp) - $signed({2'b0, r_decay});
        if (sp >= dp) begin
            peak_new = sp;
        end else if (peak_dec < 19'(peak_lo)) begin
            peak_new = peak_lo;
        end else if (peak_dec > 19'sd0) begin
            peak_new = 16'sd0;
        end else begin
            peak_new = 16'(peak_dec);
        end
    end

    // Time differences are signed, so a clock that runs backwards never expires a hold.
    always_comb begin
        hold_us    = 26'(i_cfg.hold_time_ms) * 26'(US_PER_MS);
        ihold_us   = 26'(i_cfg.input_hold_time_ms) * 26'(US_PER_MS);
        hdiff      = $signed({1'b0, r_now}) - $signed({1'b0, r_hstamp[r_ch]});
        idiff      = $signed({1'b0, r_now}) - $signed({1'b0, r_istamp[r_ch]});
        hold_load  = (sp >= dh) || (hdiff > $signed(49'(hold_us)));
        ihold_load = (sip >= dip) || (idiff > $signed(49'(ihold_us)));
        sdiff      = $signed({1'b0, i_cmd.now}) - $signed({1'b0, r_last_set});
    end

    always_comb begin
        dprod  = 36'(i_cfg.fall_rate) * 36'(r_elapsed);
        dscale = 61'(r_prod[35:6]) * 61'(DECAY_RECIP);
        mprod  = 36'(r_mag) * 36'(r_elapsed);
        sprod  = NUM_W'(r_mp) * NUM_W'(MAG_GAIN);
        tms    = (i_cfg.integration_time_ms == 14'd0) ? 14'd1 : i_cfg.integration_time_ms;
        mdiff  = 17'(sm) - 17'(dm);
        qsat   = (|div_quot[NUM_W-1:16]) ? 16'hFFFF : div_quot[15:0];
        qv     = $signed({3'b0, qsat});
        madd   = r_neg ? (19'(dm) - qv) : (19'(dm) + qv);
        if (madd < 19'(lvl_floor)) begin
            mag_new = lvl_floor;
        end else if (madd > 19'sd0) begin
            mag_new = 16'sd0;
        end else begin
            mag_new = 16'(madd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == FUNC_TICK) begin
                        n_state = B_DMUL;
                    end
                end
            end
            B_DMUL:   n_state = B_DREC;
            B_DREC:   n_state = B_CHAN;
            B_CHAN: begin
                if (dm == SILENT || sm == SILENT) begin
                    n_state = B_OUT;
                end else begin
                    n_state = B_MMUL;
                end
            end
            B_MMUL:   n_state = B_MSCALE;
            B_MSCALE: n_state = B_MSTART;
            B_MSTART: begin
                div_start = 1'b1;
                n_state   = B_MWAIT;
            end
            B_MWAIT: begin
                if (div_done) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (out_free) begin
                    n_state = ch_last ? B_IDLE : B_CHAN;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Channel state and tick datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_smag[i]   <= SILENT;
                r_speak[i]  <= SILENT;
                r_sipk[i]   <= SILENT;
                r_dmag[i]   <= SILENT;
                r_dpeak[i]  <= SILENT;
                r_dhold[i]  <= SILENT;
                r_dipk[i]   <= SILENT;
                r_hstamp[i] <= '0;
                r_istamp[i] <= '0;
            end
            r_last_set <= '0;
            r_ch       <= '0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (i_cmd_valid) begin
                        case (i_cmd.kind)
                            FUNC_SET: begin
                                r_last_set <= i_cmd.now;
                                if (ch_ok) begin
                                    r_smag[set_idx]  <= i_cmd.mag;
                                    r_speak[set_idx] <= i_cmd.peak;
                                    r_sipk[set_idx]  <= i_cmd.ipeak;
                                end
                            end
                            FUNC_RESET: begin
                                for (int i = 0; i < CHANNELS; i++) begin
                                    r_smag[i]   <= SILENT;
                                    r_speak[i]  <= SILENT;
                                    r_sipk[i]   <= SILENT;
                                    r_dmag[i]   <= SILENT;
                                    r_dpeak[i]  <= SILENT;
                                    r_dhold[i]  <= SILENT;
                                    r_dipk[i]   <= SILENT;
                                    r_hstamp[i] <= '0;
                                    r_istamp[i] <= '0;
                                end
                                r_last_set <= '0;
                            end
                            FUNC_TICK: begin
                                r_now     <= i_cmd.now;
                                r_elapsed <= i_cmd.elapsed;
                                r_idle    <= sdiff > $signed(IDLE_US);
                                r_tden    <= DEN_W'(tms) * DEN_W'(MAG_SCALE);
                                r_ch      <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                B_DMUL:  r_prod  <= NUM_W'(dprod);
                B_DREC:  r_decay <= dscale[DECAY_SHIFT +: 17];
                B_CHAN: begin
                    r_dpeak[r_ch] <= peak_new;
                    if (hold_load) begin
                        r_dhold[r_ch]  <= sp;
                        r_hstamp[r_ch] <= r_now;
                    end
                    if (ihold_load) begin
                        r_dipk[r_ch]   <= sip;
                        r_istamp[r_ch] <= r_now;
                    end
                    if (dm == SILENT) begin
                        r_dmag[r_ch] <= sm;
                    end else if (sm == SILENT) begin
                        r_dmag[r_ch] <= lvl_floor;
                    end
                    r_neg <= mdiff < 17'sd0;
                    r_mag <= 16'((mdiff < 17'sd0) ? -mdiff : mdiff);
                end
                B_MMUL:   r_mp   <= mprod;
                B_MSCALE: r_prod <= sprod;
                B_MWAIT: begin
                    if (div_done) begin
                        r_dmag[r_ch] <= mag_new;
                    end
                end
                B_OUT: begin
                    if (out_free && !ch_last) begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result register: a finished beat waits here while the sequencer moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == B_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_OUT && out_free) begin
            r_ochan <= 3'(r_ch);
            r_omag  <= shown(dm);
            r_opeak <= shown(dp);
            r_oipk  <= shown(dip);
            r_ohold <= shown(dh);
            r_oidle <= r_idle;
            r_olast <= ch_last;
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.out_channel      = r_ochan;
    assign o_out.shown_magnitude  = r_omag;
    assign o_out.shown_peak       = r_opeak;
    assign o_out.shown_input_peak = r_oipk;
    assign o_out.shown_peak_hold  = r_ohold;
    assign o_out.idle             = r_oidle;
    assign o_out.last             = r_olast;

endmodule

// ===== src/audio_meter_ballistics_top.sv =====
// Top level of the audio meter ballistics block.
//
//  channel  | dir | beat carries
//  ---------+-----+----------------------------------------------------------
//  i_cfg    | in  | register index, 16-bit write data
//  i_in     | in  | func, channel, three levels, now_time, elapsed_time
//  o_out    | out | channel, four shown levels, idle, last
//
// Set and reset beats are each handled in the idle state of the back end.
// A tick runs the decay step (pop, product, reciprocal scale) and then, per channel,
// a short path when a level is silent and a magnitude path otherwise; the shared serial
// divider, one quotient bit a cycle over 42 bits, makes the magnitude path the longer one.
// Reset (i_rst_n low at a clock edge) clears all channel state, but not every data register.
// A two-entry queue lets input beats arrive while a tick runs; a stalled
// result holds the sequencer only at the result register.
module audio_meter_ballistics_top #(
    parameter int CHANNELS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    amb_cfg_if.sink   i_cfg,
    amb_in_if.sink    i_in,
    amb_out_if.source o_out
);
    import amb_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fall_rate           <= 16'd6024;
            r_cfg.minimum_level       <= -16'sd15360;
            r_cfg.integration_time_ms <= 14'd300;
            r_cfg.hold_time_ms        <= 16'd20000;
            r_cfg.input_hold_time_ms  <= 16'd1000;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FALL_RATE:  r_cfg.fall_rate           <= i_cfg.data;
                REG_MIN_LEVEL:  r_cfg.minimum_level       <= $signed(i_cfg.data);
                REG_INTEG_MS:   r_cfg.integration_time_ms <= i_cfg.data[13:0];
                REG_HOLD_MS:    r_cfg.hold_time_ms        <= i_cfg.data;
                REG_IN_HOLD_MS: r_cfg.input_hold_time_ms  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    amb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    amb_back #(.CHANNELS(CHANNELS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

endmodule

// ===== src/amb_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module amb_checker #(
    parameter int CHANNELS = 8
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [2:0]         i_channel,
    input logic signed [15:0] i_mag,
    input logic signed [15:0] i_peak,
    input logic               i_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_channel) && $stable(i_mag))
        else $error("result beat changed while stalled");

    a_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |-> i_channel == 3'(CHANNELS - 1))
        else $error("last flag on wrong channel");

    a_next_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready && !i_last ##1 i_valid) |-> i_channel == 3'($past(i_channel) + 1))
        else $error("channels out of order within a tick");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_mag <= 16'sd0 && i_mag != 16'sh8000 && i_peak <= 16'sd0 &&
                    i_peak != 16'sh8000)
        else $error("shown level outside display range");

endmodule

bind audio_meter_ballistics_top amb_checker #(.CHANNELS(CHANNELS)) u_amb_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_out.valid),
    .i_ready   (o_out.ready),
    .i_channel (o_out.out_channel),
    .i_mag     (o_out.shown_magnitude),
    .i_peak    (o_out.shown_peak),
    .i_last    (o_out.last)
);
